// ===== hw/rtl/dtq_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dtq_pkg: shared types and constants of the delta timer queue
// Slot count, pointer widths, opcodes, result codes, controller states and
// the command / status bundles between controller and datapath.
// ----------------------------------------------------------------------------
package dtq_pkg;

    localparam int TIMERS  = 16;
    localparam int SLOT_W  = (TIMERS > 1) ? $clog2(TIMERS) : 1;
    localparam int PTR_W   = $clog2(TIMERS + 1);
    localparam int MAX_POP = (TIMERS < 16) ? TIMERS : 16;
    localparam int KCNT_W  = $clog2(MAX_POP + 1);

    localparam int ID_W    = 4;
    localparam int DELTA_W = 32;

    localparam logic [PTR_W-1:0] NIL = PTR_W'(TIMERS);

    // result status codes
    localparam logic [1:0] ST_OK     = 2'd0;
    localparam logic [1:0] ST_DUP    = 2'd1;
    localparam logic [1:0] ST_ABSENT = 2'd2;

    // result kinds
    localparam logic KIND_ALARM   = 1'b0;
    localparam logic KIND_EXPIRED = 1'b1;

    typedef enum logic [1:0] {
        OP_INSERT = 2'd0,
        OP_REMOVE = 2'd1,
        OP_EXPIRE = 2'd2,
        OP_NOP    = 2'd3
    } t_opcode;

    typedef enum logic [3:0] {
        S_IDLE,
        S_CHECK,
        S_INS_WALK,
        S_INS_LINK2,
        S_RM_WALK,
        S_RM_CAL,
        S_RM_ADD,
        S_RM_FIN,
        S_POP,
        S_REPORT
    } t_state;

    typedef enum logic [3:0] {
        CMD_NONE,
        CMD_LOAD,
        CMD_FAIL_DUP,
        CMD_FAIL_ABSENT,
        CMD_INS_CAL,
        CMD_INS_STEP,
        CMD_INS_LINK1,
        CMD_INS_LINK2,
        CMD_RM_START,
        CMD_RM_STEP,
        CMD_RM_CAL,
        CMD_RM_ADD,
        CMD_RM_FIN,
        CMD_EXP_ZERO,
        CMD_POP,
        CMD_REPORT
    } t_dp_op;

    // which pointer addresses the slot read port
    typedef enum logic [1:0] {
        RSEL_HEAD,
        RSEL_CUR,
        RSEL_ID
    } t_rsel;

    typedef struct packed {
        t_dp_op op;
        t_rsel  rsel;
    } t_dp_cmd;

    typedef struct packed {
        t_opcode op;
        logic    bad_id;
        logic    dup;
        logic    head_valid;
        logic    walk_more;
        logic    rm_more;
        logic    found;
        logic    pop_more;
        logic    out_free;
    } t_dp_stat;

endpackage

// ===== hw/rtl/dtq_datapath.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dtq_datapath: slot store, list pointers and result register
// Executes one controller command per cycle on the delta list.
// ----------------------------------------------------------------------------
module dtq_datapath (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  dtq_pkg::t_dp_cmd          i_cmd,
    output dtq_pkg::t_dp_stat         o_stat,
    input  logic [1:0]                i_opcode,
    input  logic [dtq_pkg::ID_W-1:0]  i_timer_id,
    input  logic [dtq_pkg::DELTA_W-1:0] i_delay,
    input  logic [dtq_pkg::DELTA_W-1:0] i_elapsed,
    output logic                      o_out_valid,
    input  logic                      i_out_stall,
    output logic                      o_kind,
    output logic [dtq_pkg::ID_W-1:0]  o_expired_id,
    output logic [dtq_pkg::DELTA_W-1:0] o_next_alarm,
    output logic                      o_alarm_valid,
    output logic [1:0]                o_status,
    output logic                      o_last
);

    // slot store
    logic [dtq_pkg::DELTA_W-1:0] r_delta [dtq_pkg::TIMERS];
    logic [dtq_pkg::PTR_W-1:0]   r_next  [dtq_pkg::TIMERS];
    logic [dtq_pkg::TIMERS-1:0]  r_queued, n_queued;
    logic [dtq_pkg::PTR_W-1:0]   r_head, n_head;

    // item context and walk pointers
    dtq_pkg::t_opcode            r_op;
    logic [dtq_pkg::ID_W-1:0]    r_id;
    logic [dtq_pkg::DELTA_W-1:0] r_delay, n_delay;
    logic [dtq_pkg::DELTA_W-1:0] r_elapsed;
    logic [dtq_pkg::PTR_W-1:0]   r_cur, n_cur;
    logic [dtq_pkg::PTR_W-1:0]   r_prev, n_prev;
    logic [dtq_pkg::PTR_W-1:0]   r_steps, n_steps;
    logic [dtq_pkg::KCNT_W-1:0]  r_kcnt, n_kcnt;
    logic [1:0]                  r_status, n_status;
    logic                        r_show, n_show;
    logic                        r_was_head, n_was_head;

    // result register
    logic                        r_o_valid;
    logic                        r_kind, n_kind;
    logic [dtq_pkg::ID_W-1:0]    r_xid, n_xid;
    logic [dtq_pkg::DELTA_W-1:0] r_alarm, n_alarm;
    logic                        r_aval, n_aval;
    logic [1:0]                  r_ostat, n_ostat;
    logic                        r_last, n_last;
    logic                        out_load;

    // write ports
    logic                        d_we;
    logic [dtq_pkg::SLOT_W-1:0]  d_waddr;
    logic [dtq_pkg::DELTA_W-1:0] d_wdata;
    logic                        nx_we;
    logic [dtq_pkg::SLOT_W-1:0]  nx_waddr;
    logic [dtq_pkg::PTR_W-1:0]   nx_wdata;

    // read port
    logic [dtq_pkg::PTR_W-1:0]   rd_ptr;
    logic [dtq_pkg::SLOT_W-1:0]  rd_idx;
    logic [dtq_pkg::DELTA_W-1:0] rd_delta;
    logic [dtq_pkg::PTR_W-1:0]   rd_next;
    logic [dtq_pkg::PTR_W-1:0]   rd_next_n;

    logic [dtq_pkg::SLOT_W-1:0]  id_idx, head_idx, cur_idx, prev_idx;
    logic [dtq_pkg::PTR_W-1:0]   id_ptr;
    logic                        head_valid, cur_valid, prev_valid, steps_ok;
    logic                        link_cur, rm_wh, show_now;
    logic [dtq_pkg::DELTA_W-1:0] rm_cal;

    always_comb begin
        case (i_cmd.rsel)
            dtq_pkg::RSEL_HEAD: rd_ptr = r_head;
            dtq_pkg::RSEL_CUR:  rd_ptr = r_cur;
            dtq_pkg::RSEL_ID:   rd_ptr = dtq_pkg::PTR_W'(r_id);
            default:            rd_ptr = r_head;
        endcase
    end

    assign rd_idx    = rd_ptr[dtq_pkg::SLOT_W-1:0];
    assign rd_delta  = r_delta[rd_idx];
    assign rd_next   = r_next[rd_idx];
    assign rd_next_n = (rd_next < dtq_pkg::NIL) ? rd_next : dtq_pkg::NIL;

    assign id_idx     = dtq_pkg::SLOT_W'(r_id);
    assign id_ptr     = dtq_pkg::PTR_W'(r_id);
    assign head_idx   = r_head[dtq_pkg::SLOT_W-1:0];
    assign cur_idx    = r_cur[dtq_pkg::SLOT_W-1:0];
    assign prev_idx   = r_prev[dtq_pkg::SLOT_W-1:0];
    assign head_valid = r_head < dtq_pkg::NIL;
    assign cur_valid  = r_cur < dtq_pkg::NIL;
    assign prev_valid = r_prev < dtq_pkg::NIL;
    assign steps_ok   = r_steps < dtq_pkg::PTR_W'(dtq_pkg::TIMERS);
    assign link_cur   = cur_valid && steps_ok;
    assign rm_wh      = (r_head == id_ptr);
    assign rm_cal     = (rm_wh && rd_delta >= r_elapsed) ? (rd_delta - r_elapsed) : rd_delta;
    assign show_now   = r_show && head_valid;
    assign out_load   = (i_cmd.op == dtq_pkg::CMD_POP) || (i_cmd.op == dtq_pkg::CMD_REPORT);

    // status to the controller
    always_comb begin
        o_stat.op         = r_op;
        o_stat.bad_id     = 32'(r_id) >= 32'(dtq_pkg::TIMERS);
        o_stat.dup        = r_queued[id_idx];
        o_stat.head_valid = head_valid;
        o_stat.walk_more  = cur_valid && steps_ok && (r_delay >= rd_delta);
        o_stat.rm_more    = cur_valid && (r_cur != id_ptr) && steps_ok;
        o_stat.found      = (r_cur == id_ptr);
        o_stat.pop_more   = head_valid && (r_kcnt < dtq_pkg::KCNT_W'(dtq_pkg::MAX_POP))
                            && (rd_delta == '0);
        o_stat.out_free   = !r_o_valid || !i_out_stall;
    end

    always_comb begin
        d_we       = 1'b0;
        d_waddr    = rd_idx;
        d_wdata    = rd_delta;
        nx_we      = 1'b0;
        nx_waddr   = id_idx;
        nx_wdata   = dtq_pkg::NIL;
        n_queued   = r_queued;
        n_head     = r_head;
        n_delay    = r_delay;
        n_cur      = r_cur;
        n_prev     = r_prev;
        n_steps    = r_steps;
        n_kcnt     = r_kcnt;
        n_status   = r_status;
        n_show     = r_show;
        n_was_head = r_was_head;
        n_kind     = r_kind;
        n_xid      = r_xid;
        n_alarm    = r_alarm;
        n_aval     = r_aval;
        n_ostat    = r_ostat;
        n_last     = r_last;
        case (i_cmd.op)
            dtq_pkg::CMD_LOAD: begin
                n_delay  = i_delay;
                n_status = dtq_pkg::ST_OK;
                n_show   = (i_opcode != dtq_pkg::OP_NOP);
            end
            dtq_pkg::CMD_FAIL_DUP: begin
                n_status = dtq_pkg::ST_DUP;
                n_show   = 1'b0;
            end
            dtq_pkg::CMD_FAIL_ABSENT: begin
                n_status = dtq_pkg::ST_ABSENT;
                n_show   = 1'b0;
            end
            dtq_pkg::CMD_INS_CAL: begin
                // late calibration leaves the head untouched
                if (head_valid && rd_delta >= r_elapsed) begin
                    d_we    = 1'b1;
                    d_waddr = head_idx;
                    d_wdata = rd_delta - r_elapsed;
                end
                n_cur   = r_head;
                n_prev  = dtq_pkg::NIL;
                n_steps = '0;
            end
            dtq_pkg::CMD_INS_STEP: begin
                n_delay = r_delay - rd_delta;
                n_prev  = r_cur;
                n_cur   = rd_next;
                n_steps = r_steps + 1'b1;
            end
            dtq_pkg::CMD_INS_LINK1: begin
                if (link_cur) begin
                    d_we    = 1'b1;
                    d_waddr = cur_idx;
                    d_wdata = rd_delta - r_delay;
                end
                nx_we            = 1'b1;
                nx_waddr         = id_idx;
                nx_wdata         = link_cur ? r_cur : dtq_pkg::NIL;
                n_queued[id_idx] = 1'b1;
            end
            dtq_pkg::CMD_INS_LINK2: begin
                d_we    = 1'b1;
                d_waddr = id_idx;
                d_wdata = r_delay;
                if (prev_valid) begin
                    nx_we    = 1'b1;
                    nx_waddr = prev_idx;
                    nx_wdata = id_ptr;
                end else begin
                    n_head = id_ptr;
                end
            end
            dtq_pkg::CMD_RM_START: begin
                n_cur   = r_head;
                n_prev  = dtq_pkg::NIL;
                n_steps = '0;
            end
            dtq_pkg::CMD_RM_STEP: begin
                n_prev  = r_cur;
                n_cur   = rd_next;
                n_steps = r_steps + 1'b1;
            end
            dtq_pkg::CMD_RM_CAL: begin
                d_we       = 1'b1;
                d_waddr    = id_idx;
                d_wdata    = rm_cal;
                n_delay    = rm_cal;
                n_was_head = rm_wh;
                n_cur      = rd_next_n;
            end
            dtq_pkg::CMD_RM_ADD: begin
                // successor takes over the removed delta
                if (cur_valid) begin
                    d_we    = 1'b1;
                    d_waddr = cur_idx;
                    d_wdata = rd_delta + r_delay;
                end
                if (prev_valid) begin
                    nx_we    = 1'b1;
                    nx_waddr = prev_idx;
                    nx_wdata = r_cur;
                end else begin
                    n_head = r_cur;
                end
            end
            dtq_pkg::CMD_RM_FIN: begin
                n_queued[id_idx] = 1'b0;
                nx_we            = 1'b1;
                nx_waddr         = id_idx;
                nx_wdata         = dtq_pkg::NIL;
                n_show           = r_was_head;
            end
            dtq_pkg::CMD_EXP_ZERO: begin
                d_we    = 1'b1;
                d_waddr = head_idx;
                d_wdata = '0;
                n_kcnt  = '0;
            end
            dtq_pkg::CMD_POP: begin
                n_kind             = dtq_pkg::KIND_EXPIRED;
                n_xid              = dtq_pkg::ID_W'(r_head);
                n_alarm            = '0;
                n_aval             = 1'b0;
                n_ostat            = dtq_pkg::ST_OK;
                n_last             = 1'b0;
                n_head             = rd_next_n;
                n_queued[head_idx] = 1'b0;
                nx_we              = 1'b1;
                nx_waddr           = head_idx;
                nx_wdata           = dtq_pkg::NIL;
                n_kcnt             = r_kcnt + 1'b1;
            end
            dtq_pkg::CMD_REPORT: begin
                n_kind  = dtq_pkg::KIND_ALARM;
                n_xid   = '0;
                n_alarm = show_now ? rd_delta : '0;
                n_aval  = show_now;
                n_ostat = r_status;
                n_last  = 1'b1;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (d_we) begin
            r_delta[d_waddr] <= d_wdata;
        end
        if (nx_we) begin
            r_next[nx_waddr] <= nx_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_queued  <= '0;
            r_head    <= dtq_pkg::NIL;
            r_o_valid <= 1'b0;
        end else begin
            r_queued <= n_queued;
            r_head   <= n_head;
            if (out_load) begin
                r_o_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.op == dtq_pkg::CMD_LOAD) begin
            r_op      <= dtq_pkg::t_opcode'(i_opcode);
            r_id      <= i_timer_id;
            r_elapsed <= i_elapsed;
        end
        r_delay    <= n_delay;
        r_cur      <= n_cur;
        r_prev     <= n_prev;
        r_steps    <= n_steps;
        r_kcnt     <= n_kcnt;
        r_status   <= n_status;
        r_show     <= n_show;
        r_was_head <= n_was_head;
        r_kind     <= n_kind;
        r_xid      <= n_xid;
        r_alarm    <= n_alarm;
        r_aval     <= n_aval;
        r_ostat    <= n_ostat;
        r_last     <= n_last;
    end

    assign o_out_valid   = r_o_valid;
    assign o_kind        = r_kind;
    assign o_expired_id  = r_xid;
    assign o_next_alarm  = r_alarm;
    assign o_alarm_valid = r_aval;
    assign o_status      = r_ostat;
    assign o_last        = r_last;

    // a live head always names a queued slot
    a_head_queued: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_head < dtq_pkg::NIL) |-> r_queued[head_idx])
        else $error("head slot not marked queued");

    // every pop advances the head
    a_pop_moves: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.op == dtq_pkg::CMD_POP) |=> (r_head != $past(r_head)))
        else $error("pop left head in place");

    // results are only loaded into a free output register
    a_load_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_load |-> (!r_o_valid || !i_out_stall))
        else $error("result overwritten while stalled");

endmodule

// ===== hw/rtl/dtq_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dtq_ctrl: sequencer of the delta timer queue
// Steps each operation through check, list walk and splice or expiry pops, and report.
// ----------------------------------------------------------------------------
module dtq_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  dtq_pkg::t_dp_stat  i_stat,
    output dtq_pkg::t_dp_cmd   o_cmd
);

    dtq_pkg::t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= dtq_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            dtq_pkg::S_IDLE: begin
                if (i_in_valid) n_state = dtq_pkg::S_CHECK;
            end
            dtq_pkg::S_CHECK: begin
                case (i_stat.op)
                    dtq_pkg::OP_INSERT: begin
                        if (i_stat.bad_id || i_stat.dup) n_state = dtq_pkg::S_REPORT;
                        else                             n_state = dtq_pkg::S_INS_WALK;
                    end
                    dtq_pkg::OP_REMOVE: begin
                        if (i_stat.bad_id || !i_stat.dup) n_state = dtq_pkg::S_REPORT;
                        else                              n_state = dtq_pkg::S_RM_WALK;
                    end
                    dtq_pkg::OP_EXPIRE: begin
                        if (i_stat.head_valid) n_state = dtq_pkg::S_POP;
                        else                   n_state = dtq_pkg::S_REPORT;
                    end
                    default: n_state = dtq_pkg::S_REPORT;
                endcase
            end
            dtq_pkg::S_INS_WALK: begin
                if (!i_stat.walk_more) n_state = dtq_pkg::S_INS_LINK2;
            end
            dtq_pkg::S_INS_LINK2: n_state = dtq_pkg::S_REPORT;
            dtq_pkg::S_RM_WALK: begin
                if (!i_stat.rm_more) begin
                    if (i_stat.found) n_state = dtq_pkg::S_RM_CAL;
                    else              n_state = dtq_pkg::S_REPORT;
                end
            end
            dtq_pkg::S_RM_CAL: n_state = dtq_pkg::S_RM_ADD;
            dtq_pkg::S_RM_ADD: n_state = dtq_pkg::S_RM_FIN;
            dtq_pkg::S_RM_FIN: n_state = dtq_pkg::S_REPORT;
            dtq_pkg::S_POP: begin
                if (!i_stat.pop_more) n_state = dtq_pkg::S_REPORT;
            end
            dtq_pkg::S_REPORT: begin
                if (i_stat.out_free) n_state = dtq_pkg::S_IDLE;
            end
            default: n_state = dtq_pkg::S_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        o_in_stall = (r_state != dtq_pkg::S_IDLE);
        o_cmd.op   = dtq_pkg::CMD_NONE;
        o_cmd.rsel = dtq_pkg::RSEL_HEAD;
        case (r_state)
            dtq_pkg::S_IDLE: begin
                if (i_in_valid) o_cmd.op = dtq_pkg::CMD_LOAD;
            end
            dtq_pkg::S_CHECK: begin
                case (i_stat.op)
                    dtq_pkg::OP_INSERT: begin
                        if (i_stat.bad_id)   o_cmd.op = dtq_pkg::CMD_FAIL_ABSENT;
                        else if (i_stat.dup) o_cmd.op = dtq_pkg::CMD_FAIL_DUP;
                        else                 o_cmd.op = dtq_pkg::CMD_INS_CAL;
                    end
                    dtq_pkg::OP_REMOVE: begin
                        if (i_stat.bad_id || !i_stat.dup) o_cmd.op = dtq_pkg::CMD_FAIL_ABSENT;
                        else                              o_cmd.op = dtq_pkg::CMD_RM_START;
                    end
                    dtq_pkg::OP_EXPIRE: begin
                        if (i_stat.head_valid) o_cmd.op = dtq_pkg::CMD_EXP_ZERO;
                    end
                    default: o_cmd.op = dtq_pkg::CMD_NONE;
                endcase
            end
            dtq_pkg::S_INS_WALK: begin
                o_cmd.rsel = dtq_pkg::RSEL_CUR;
                if (i_stat.walk_more) o_cmd.op = dtq_pkg::CMD_INS_STEP;
                else                  o_cmd.op = dtq_pkg::CMD_INS_LINK1;
            end
            dtq_pkg::S_INS_LINK2: o_cmd.op = dtq_pkg::CMD_INS_LINK2;
            dtq_pkg::S_RM_WALK: begin
                o_cmd.rsel = dtq_pkg::RSEL_CUR;
                if (i_stat.rm_more)     o_cmd.op = dtq_pkg::CMD_RM_STEP;
                else if (!i_stat.found) o_cmd.op = dtq_pkg::CMD_FAIL_ABSENT;
            end
            dtq_pkg::S_RM_CAL: begin
                o_cmd.rsel = dtq_pkg::RSEL_ID;
                o_cmd.op   = dtq_pkg::CMD_RM_CAL;
            end
            dtq_pkg::S_RM_ADD: begin
                o_cmd.rsel = dtq_pkg::RSEL_CUR;
                o_cmd.op   = dtq_pkg::CMD_RM_ADD;
            end
            dtq_pkg::S_RM_FIN: o_cmd.op = dtq_pkg::CMD_RM_FIN;
            dtq_pkg::S_POP: begin
                if (i_stat.pop_more && i_stat.out_free) o_cmd.op = dtq_pkg::CMD_POP;
            end
            dtq_pkg::S_REPORT: begin
                if (i_stat.out_free) o_cmd.op = dtq_pkg::CMD_REPORT;
            end
            default: o_cmd.op = dtq_pkg::CMD_NONE;
        endcase
    end

endmodule

// ===== hw/rtl/delta_timer_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// delta_timer_queue: sorted delta list of software timers
// Insert, remove and alarm-expire operations on a list of timer slots,
// each slot holding its delay relative to the slot ahead of it.
// ----------------------------------------------------------------------------
//
//  channel  | direction | handshake              | word
//  ---------+-----------+------------------------+-------------------------------
//  in       | input     | i_in_valid/o_in_stall  | opcode, timer_id, delay, elapsed
//  out      | output    | o_out_valid/i_out_stall| kind, expired_id, next_alarm,
//           |           |                        | alarm_valid, status, last
//
//  One operation at a time; the list walk over the slot store sets the time.
//  Insert walks past the slots ahead of its place, remove walks to the slot's
//  position in the list and expire pops the expired timers one by one;
//  errors and no-ops go straight to the report. The sequence waits while
//  i_out_stall holds a waiting word. i_rst_n is synchronous, active low; it
//  empties the queue at once, with no clearing pass. The output register
//  holds a word while i_out_stall is high; the input is stalled from
//  acceptance until the final word of the operation is loaded.
//
module delta_timer_queue (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [1:0]  i_opcode,
    input  logic [3:0]  i_timer_id,
    input  logic [31:0] i_delay,
    input  logic [31:0] i_elapsed,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic        o_kind,
    output logic [3:0]  o_expired_id,
    output logic [31:0] o_next_alarm,
    output logic        o_alarm_valid,
    output logic [1:0]  o_status,
    output logic        o_last
);

    // command/status link between sequencer and datapath
    dtq_pkg::t_dp_cmd  cmd;
    dtq_pkg::t_dp_stat stat;

    // sequencer: one command per cycle unless held by i_out_stall, walks the list slot by slot
    dtq_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    // datapath: slot deltas, links, queued flags, head pointer, output word
    dtq_datapath u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .o_stat        (stat),
        .i_opcode      (i_opcode),
        .i_timer_id    (i_timer_id),
        .i_delay       (i_delay),
        .i_elapsed     (i_elapsed),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_kind        (o_kind),
        .o_expired_id  (o_expired_id),
        .o_next_alarm  (o_next_alarm),
        .o_alarm_valid (o_alarm_valid),
        .o_status      (o_status),
        .o_last        (o_last)
    );

endmodule

// ===== sim/timer_check_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// timer_check_pkg: delta timer queue scoreboard
// Holds a cycle-free model of the timer delta list and checks the result
// words of the block, in order, against the words the model predicts.
// ----------------------------------------------------------------------------
package timer_check_pkg;

    import dtq_pkg::*;

    typedef struct packed {
        logic               kind;
        logic [ID_W-1:0]    expired_id;
        logic [DELTA_W-1:0] next_alarm;
        logic               alarm_valid;
        logic [1:0]         status;
        logic               last;
    } alarm_word_t;

    class delta_list_scoreboard;

        // model of the list: per-slot delta to the slot ahead, link, queued flag
        logic [DELTA_W-1:0] gap_ticks [TIMERS];
        logic [PTR_W-1:0]   link      [TIMERS];
        bit                 armed     [TIMERS];
        logic [PTR_W-1:0]   first;

        alarm_word_t due_words[$];

        int failures;
        int words_checked;
        int deepest_pop;
        int op_seen [4];

        function new();
            for (int i = 0; i < TIMERS; i++) begin
                gap_ticks[i] = '0;
                link[i]      = NIL;
                armed[i]     = 1'b0;
            end
            first = NIL;
            failures = 0;
            words_checked = 0;
            deepest_pop = 0;
            foreach (op_seen[i]) op_seen[i] = 0;
        endfunction

        function int pending();
            return due_words.size();
        endfunction

        function int occupancy();
            int n;
            n = 0;
            for (int i = 0; i < TIMERS; i++) n += armed[i];
            return n;
        endfunction

        // random slot that is (or is not) queued; any slot if none qualifies
        function logic [ID_W-1:0] pick_id(bit want_armed);
            logic [ID_W-1:0] pool[$];
            for (int i = 0; i < TIMERS; i++)
                if (armed[i] == want_armed) pool.push_back(ID_W'(i));
            if (pool.size() == 0) return ID_W'($urandom);
            return pool[$urandom_range(0, pool.size() - 1)];
        endfunction

        function void push_word(logic kind, logic [ID_W-1:0] id, logic [DELTA_W-1:0] alarm,
                                logic av, logic [1:0] st, logic lst);
            alarm_word_t w;
            w.kind        = kind;
            w.expired_id  = id;
            w.next_alarm  = alarm;
            w.alarm_valid = av;
            w.status      = st;
            w.last        = lst;
            due_words.push_back(w);
        endfunction

        function void head_alarm(logic [1:0] st);
            if (first != NIL) push_word(KIND_ALARM, '0, gap_ticks[first], 1'b1, st, 1'b1);
            else push_word(KIND_ALARM, '0, '0, 1'b0, st, 1'b1);
        endfunction

        // late calibration leaves the head as it is
        function void age_head(logic [DELTA_W-1:0] elapsed);
            if (first != NIL && gap_ticks[first] >= elapsed)
                gap_ticks[first] -= elapsed;
        endfunction

        function void splice_timer(logic [ID_W-1:0] id, logic [DELTA_W-1:0] delay,
                                   logic [DELTA_W-1:0] elapsed);
            logic [PTR_W-1:0] prev;
            logic [PTR_W-1:0] cur;
            int steps;
            if (int'(id) >= TIMERS) begin
                push_word(KIND_ALARM, '0, '0, 1'b0, ST_ABSENT, 1'b1);
                return;
            end
            if (armed[id]) begin
                push_word(KIND_ALARM, '0, '0, 1'b0, ST_DUP, 1'b1);
                return;
            end
            age_head(elapsed);
            prev  = NIL;
            cur   = first;
            steps = 0;
            while (cur != NIL && steps < TIMERS && delay >= gap_ticks[cur]) begin
                delay -= gap_ticks[cur];
                prev   = cur;
                cur    = link[cur];
                steps++;
            end
            if (cur == NIL || steps >= TIMERS) cur = NIL;
            else gap_ticks[cur] -= delay;
            gap_ticks[id] = delay;
            link[id]      = cur;
            armed[id]     = 1'b1;
            if (prev != NIL) link[prev] = PTR_W'(id);
            else first = PTR_W'(id);
            head_alarm(ST_OK);
        endfunction

        function void unlink_timer(logic [ID_W-1:0] id, logic [DELTA_W-1:0] elapsed);
            logic [PTR_W-1:0] prev;
            logic [PTR_W-1:0] cur;
            logic [PTR_W-1:0] nxt;
            bit at_head;
            int steps;
            if (int'(id) >= TIMERS || !armed[id]) begin
                push_word(KIND_ALARM, '0, '0, 1'b0, ST_ABSENT, 1'b1);
                return;
            end
            prev  = NIL;
            cur   = first;
            steps = 0;
            while (cur != NIL && cur != PTR_W'(id) && steps < TIMERS) begin
                prev = cur;
                cur  = link[cur];
                steps++;
            end
            if (cur != PTR_W'(id)) begin
                push_word(KIND_ALARM, '0, '0, 1'b0, ST_ABSENT, 1'b1);
                return;
            end
            at_head = (first == PTR_W'(id));
            if (at_head) age_head(elapsed);
            nxt = link[id];
            // successor inherits the removed delta (wraps mod 2^32)
            if (nxt != NIL) gap_ticks[nxt] += gap_ticks[id];
            if (prev != NIL) link[prev] = nxt;
            else first = nxt;
            armed[id] = 1'b0;
            link[id]  = NIL;
            if (at_head) head_alarm(ST_OK);
            else push_word(KIND_ALARM, '0, '0, 1'b0, ST_OK, 1'b1);
        endfunction

        function void pop_expired();
            logic [PTR_W-1:0] h;
            int k;
            k = 0;
            if (first != NIL) begin
                gap_ticks[first] = '0;
                while (first != NIL && k < MAX_POP && gap_ticks[first] == '0) begin
                    h        = first;
                    first    = link[h];
                    armed[h] = 1'b0;
                    link[h]  = NIL;
                    push_word(KIND_EXPIRED, ID_W'(h), '0, 1'b0, ST_OK, 1'b0);
                    k++;
                end
            end
            if (k > deepest_pop) deepest_pop = k;
            head_alarm(ST_OK);
        endfunction

        // one accepted input word
        function void note_request(t_opcode op, logic [ID_W-1:0] id,
                                   logic [DELTA_W-1:0] delay, logic [DELTA_W-1:0] elapsed);
            op_seen[op]++;
            case (op)
                OP_INSERT: splice_timer(id, delay, elapsed);
                OP_REMOVE: unlink_timer(id, elapsed);
                OP_EXPIRE: pop_expired();
                default:   push_word(KIND_ALARM, '0, '0, 1'b0, ST_OK, 1'b1);
            endcase
        endfunction

        // one accepted result word against the oldest prediction
        function void check_report(alarm_word_t got);
            alarm_word_t want;
            words_checked++;
            if (due_words.size() == 0) begin
                failures++;
                if (failures <= 10)
                    $display("%0t UNEXPECTED word: kind=%0d id=%0d alarm=%h av=%0d st=%0d last=%0d",
                             $realtime, got.kind, got.expired_id, got.next_alarm,
                             got.alarm_valid, got.status, got.last);
                return;
            end
            want = due_words.pop_front();
            if (got.kind !== want.kind || got.expired_id !== want.expired_id ||
                got.next_alarm !== want.next_alarm || got.alarm_valid !== want.alarm_valid ||
                got.status !== want.status || got.last !== want.last) begin
                failures++;
                if (failures <= 10) begin
                    $display("%0t MISMATCH expected kind=%0d id=%0d alarm=%h av=%0d st=%0d last=%0d",
                             $realtime, want.kind, want.expired_id, want.next_alarm,
                             want.alarm_valid, want.status, want.last);
                    $display("%0t          actual   kind=%0d id=%0d alarm=%h av=%0d st=%0d last=%0d",
                             $realtime, got.kind, got.expired_id, got.next_alarm,
                             got.alarm_valid, got.status, got.last);
                end
            end
        endfunction

    endclass

endpackage

// ===== sim/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the delta timer queue
// Drives insert / remove / expire / no-op words with random sender gaps and
// receiver stalls, predicts every result word with a list model and checks
// the words in order, field by field.
// ----------------------------------------------------------------------------
module tb_top;

    import dtq_pkg::*;
    import timer_check_pkg::*;

    localparam int ITEMS          = 300;
    localparam int TAIL_START     = 255;   // no idling from here on
    localparam int DRAIN_CYCLES   = 40;    // longer than the longest op, with margin
    localparam int WATCHDOG_LIMIT = 2000;  // cycles without any handshake

    logic        i_clk         = 1'b0;
    logic        i_rst_n       = 1'b0;
    logic        i_in_valid    = 1'b0;
    logic [1:0]  i_opcode      = OP_NOP;
    logic [3:0]  i_timer_id    = '0;
    logic [31:0] i_delay       = '0;
    logic [31:0] i_elapsed     = '0;
    logic        i_out_stall   = 1'b0;
    logic        o_in_stall;
    logic        o_out_valid;
    logic        o_kind;
    logic [3:0]  o_expired_id;
    logic [31:0] o_next_alarm;
    logic        o_alarm_valid;
    logic [1:0]  o_status;
    logic        o_last;

    delta_list_scoreboard sb;
    alarm_word_t          seen_word;
    int                   words_sent  = 0;
    int                   quiet_cycles = 0;
    int                   stall_left  = 0;
    bit                   quiet_tail  = 1'b0;

    delta_timer_queue dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_opcode      (i_opcode),
        .i_timer_id    (i_timer_id),
        .i_delay       (i_delay),
        .i_elapsed     (i_elapsed),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_kind        (o_kind),
        .o_expired_id  (o_expired_id),
        .o_next_alarm  (o_next_alarm),
        .o_alarm_valid (o_alarm_valid),
        .o_status      (o_status),
        .o_last        (o_last)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Receiver side: random stall bursts, none in the tail.
    always @(posedge i_clk) begin
        if (stall_left > 0) begin
            stall_left  <= stall_left - 1;
            i_out_stall <= 1'b1;
        end else if (!quiet_tail && $urandom_range(0, 7) == 0) begin
            stall_left  <= $urandom_range(0, 16);
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= 1'b0;
        end
    end

    // Output monitor and handshake watchdog counter. Values are sampled at the
    // edge, before any update scheduled at that edge lands.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            quiet_cycles <= 0;
        end else begin
            if (o_out_valid && !i_out_stall) begin
                seen_word.kind        = o_kind;
                seen_word.expired_id  = o_expired_id;
                seen_word.next_alarm  = o_next_alarm;
                seen_word.alarm_valid = o_alarm_valid;
                seen_word.status      = o_status;
                seen_word.last        = o_last;
                sb.check_report(seen_word);
            end
            if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        while (quiet_cycles < WATCHDOG_LIMIT) @(posedge i_clk);
        $display("Watchdog: no handshake for %0d cycles, %0d words still due",
                 WATCHDOG_LIMIT, sb.pending());
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // Present one word, hold it until accepted, then hand it to the model.
    // An optional gap comes first; valid stays high for back-to-back words.
    task automatic send_word(t_opcode op, logic [3:0] id, logic [31:0] delay,
                             logic [31:0] elapsed);
        if (!quiet_tail && $urandom_range(0, 3) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 17)) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_opcode   <= op;
        i_timer_id <= id;
        i_delay    <= delay;
        i_elapsed  <= elapsed;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        sb.note_request(op, id, delay, elapsed);
        words_sent++;
    endtask

    // Tick values biased toward small numbers (ties, zero deltas, calibration
    // hits) with the extremes and full-range values mixed in.
    function automatic logic [31:0] pick_ticks();
        case ($urandom_range(0, 5))
            0:       return 32'($urandom_range(0, 3));
            1:       return 32'($urandom_range(0, 200));
            2:       return ($urandom_range(0, 1) != 0) ? 32'hFFFF_FFFF : 32'h0;
            3:       return 32'($urandom_range(0, 65535));
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [31:0] pick_elapsed();
        return ($urandom_range(0, 2) == 0) ? 32'h0 : pick_ticks();
    endfunction

    task automatic random_word();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 45) begin
            // mostly free slots; the rest hit queued ones (duplicate status)
            send_word(OP_INSERT, sb.pick_id($urandom_range(0, 4) == 0), pick_ticks(),
                      pick_elapsed());
        end else if (roll < 70) begin
            send_word(OP_REMOVE, sb.pick_id($urandom_range(0, 4) != 0), $urandom,
                      pick_elapsed());
        end else if (roll < 93) begin
            send_word(OP_EXPIRE, 4'($urandom), $urandom, $urandom);
        end else begin
            send_word(OP_NOP, 4'($urandom), $urandom, $urandom);
        end
    endtask

    // Fill every free slot with short, often equal delays, then fire the
    // alarm a few times: long runs of zero deltas pop in one expire.
    task automatic fill_and_fire();
        logic [31:0] spread;
        spread = ($urandom_range(0, 2) == 0) ? 32'd0 : 32'($urandom_range(1, 3));
        while (sb.occupancy() < TIMERS)
            send_word(OP_INSERT, sb.pick_id(1'b0), 32'($urandom_range(0, spread)),
                      ($urandom_range(0, 3) == 0) ? 32'($urandom_range(0, 2)) : 32'h0);
        repeat ($urandom_range(1, 4))
            send_word(OP_EXPIRE, 4'($urandom), $urandom, $urandom);
    endtask

    initial begin
        sb = new();
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed opening: empty-queue cases, extremes, every opcode.
        send_word(OP_EXPIRE, 4'd0,  32'h0,         32'hFFFF_FFFF);  // empty expire
        send_word(OP_REMOVE, 4'd5,  32'h0,         32'h0);          // absent id
        send_word(OP_NOP,    4'hF,  32'hFFFF_FFFF, 32'hFFFF_FFFF);  // opcode three
        send_word(OP_INSERT, 4'd0,  32'h0,         32'h0);          // zero delay head
        send_word(OP_INSERT, 4'hF,  32'hFFFF_FFFF, 32'hFFFF_FFFF);  // late calibration, tail
        send_word(OP_INSERT, 4'd0,  32'd77,        32'h0);          // already queued
        send_word(OP_INSERT, 4'd7,  32'd1000,      32'h0);
        send_word(OP_REMOVE, 4'd7,  32'h0,         32'd3);          // non-head: alarm kept
        send_word(OP_EXPIRE, 4'd9,  32'h1234_5678, 32'd5);          // pops zero-delta head
        send_word(OP_INSERT, 4'd3,  32'd500,       32'd100);        // calibrated head
        send_word(OP_INSERT, 4'd4,  32'd500,       32'h0);          // tie: lands behind 3
        send_word(OP_INSERT, 4'd9,  32'd499,       32'd600);        // too late, new head
        send_word(OP_REMOVE, 4'd9,  32'h0,         32'd99);         // head removal
        send_word(OP_EXPIRE, 4'd0,  32'h0,         32'h0);          // pops 3 and 4
        send_word(OP_REMOVE, 4'hF,  32'h0,         32'd5);          // lone head
        send_word(OP_EXPIRE, 4'd0,  32'h0,         32'h0);
        send_word(OP_INSERT, 4'd1,  32'd10,        32'h0);
        send_word(OP_REMOVE, 4'd1,  32'h0,         32'd20);         // late on removal
        send_word(OP_REMOVE, 4'd1,  32'h0,         32'h0);          // removed twice
        send_word(OP_INSERT, 4'd8,  32'h8000_0000, 32'h0);
        send_word(OP_INSERT, 4'd2,  32'h7FFF_FFFF, 32'h0);
        send_word(OP_INSERT, 4'd6,  32'h8000_0000, 32'h0);          // zero remainder
        send_word(OP_EXPIRE, 4'd0,  32'h0,         32'h0);

        while (words_sent < ITEMS) begin
            if (words_sent >= TAIL_START) quiet_tail <= 1'b1;
            if ($urandom_range(0, 24) == 0) fill_and_fire();
            else random_word();
        end
        i_in_valid <= 1'b0;

        while (sb.pending() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Ran %0d inserts, %0d removes, %0d expires, %0d no-ops; %0d result words checked",
                 sb.op_seen[OP_INSERT], sb.op_seen[OP_REMOVE], sb.op_seen[OP_EXPIRE],
                 sb.op_seen[OP_NOP], sb.words_checked);
        $display("Longest expire burst popped %0d timers; %0d failing words",
                 sb.deepest_pop, sb.failures);
        if (sb.failures == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
